### rtl/jsm_pkg.sv
// Shared types and codes for the JTAG shift master.
// No dependencies; imported by every other file of the block.
`default_nettype none

package jsm_pkg;

	// command / job codes
	localparam logic [1:0] JOB_TICK = 2'd0;
	localparam logic [1:0] JOB_TMS  = 2'd1;
	localparam logic [1:0] JOB_LSB  = 2'd2;
	localparam logic [1:0] JOB_MSB  = 2'd3;

	// sequencer phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_EN     = 1'd1;

	localparam int HALF_PERIOD_RST = 80;
	localparam int MSB_JOB_BITS    = 8;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] out_bits;
		logic [5:0]  bit_count;
		logic        hold_tms;
		logic        target_out_pin;
	} req_item_t;

	typedef struct packed {
		logic        tck;
		logic        tms_pin;
		logic        data_pin;
		logic        pins_driven;
		logic        busy_res;
		logic        done_res;
		logic [31:0] read_data;
	} rsp_item_t;

endpackage

`default_nettype wire

### rtl/jsm_ifs.sv
// Valid/ready channel interfaces for the JTAG shift master.
// Depends on jsm_pkg for the beat types.
`default_nettype none

interface jsm_req_if import jsm_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jsm_rsp_if import jsm_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/jsm_cfg.sv
// Configuration registers: half period and pin enable.
// Depends on jsm_pkg for register indexes and reset values.
`default_nettype none

module jsm_cfg import jsm_pkg::*; #(
	parameter int DELAY_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [CFG_IDX_W-1:0]   index,
	input  wire logic [DELAY_WIDTH-1:0] wdata,
	output logic      [DELAY_WIDTH-1:0] half_period_q,
	output logic                        port_en_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= DELAY_WIDTH'(HALF_PERIOD_RST);
			port_en_q     <= 1'b0;
		end else if (wr_en) begin
			case (index)
				CFG_HALF_PERIOD: half_period_q <= wdata;
				CFG_PORT_EN:     port_en_q     <= wdata[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/jsm_engine.sv
// Tick engine: shift registers, bit counter, half-period timer and pin latches.
// One tick per enabled cycle; result is combinational for the output stage.
// Depends on jsm_pkg.
`default_nettype none

module jsm_engine import jsm_pkg::*; #(
	parameter int MAX_SHIFT_BITS = 32,
	parameter int DELAY_WIDTH    = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire req_item_t              item,
	input  wire logic [DELAY_WIDTH-1:0] half_period,
	input  wire logic                   port_en,
	output rsp_item_t                   res
);

	localparam int SW   = MAX_SHIFT_BITS;
	localparam int BL_W = $clog2(MAX_SHIFT_BITS + 1);

	logic [SW-1:0]          out_shift_q, in_shift_q, n_out, n_in;
	logic [BL_W-1:0]        bits_left_q, n_bl;
	logic [DELAY_WIDTH-1:0] wait_q, n_wait, half_len;
	logic [1:0]             phase_q, job_q, n_phase, n_job;
	logic                   tck_q, tms_q, data_q, n_tck, n_tms, n_data;
	logic                   done, do_drive;
	logic [31:0]            len_w;

	assign half_len = (half_period == '0) ? DELAY_WIDTH'(1) : half_period;

	always_comb begin
		n_out    = out_shift_q;
		n_in     = in_shift_q;
		n_bl     = bits_left_q;
		n_wait   = wait_q;
		n_phase  = phase_q;
		n_job    = job_q;
		n_tck    = tck_q;
		n_tms    = tms_q;
		n_data   = data_q;
		done     = 1'b0;
		do_drive = 1'b0;
		len_w    = 32'(item.bit_count);

		if (phase_q == PH_IDLE) begin
			if (item.cmd != JOB_TICK) begin
				n_job = item.cmd;
				if (len_w > 32'(MAX_SHIFT_BITS))
					len_w = 32'(MAX_SHIFT_BITS);
				if (item.cmd == JOB_MSB) begin
					if (len_w > 32'(MSB_JOB_BITS))
						len_w = 32'(MSB_JOB_BITS);
					n_out = SW'({56'd0, item.out_bits[7:0]});
				end else begin
					n_out = SW'({32'd0, item.out_bits});
				end
				if (item.cmd != JOB_TMS) begin
					n_tms = item.hold_tms;
					n_in  = '0;
				end
				n_bl = BL_W'(len_w);
				if (len_w == 32'd0)
					done = 1'b1;
				else
					do_drive = 1'b1;
			end
		end else if (wait_q > DELAY_WIDTH'(1)) begin
			n_wait = wait_q - DELAY_WIDTH'(1);
		end else if (phase_q == PH_LOW) begin
			// sample on the rising TCK edge
			case (job_q)
				JOB_LSB: n_in = {in_shift_q[SW-2:0], item.target_out_pin};
				JOB_MSB: n_in = SW'({56'd0, item.target_out_pin, in_shift_q[7:1]});
				default: ;
			endcase
			n_tck   = 1'b1;
			n_phase = PH_HIGH;
			n_wait  = half_len;
		end else begin
			n_tck = 1'b0;
			if (bits_left_q != '0)
				n_bl = bits_left_q - BL_W'(1);
			if (n_bl == '0) begin
				n_phase = PH_IDLE;
				n_wait  = '0;
				done    = 1'b1;
			end else begin
				do_drive = 1'b1;
			end
		end

		if (do_drive) begin
			case (n_job)
				JOB_TMS: begin
					n_tms = n_out[0];
					n_out = n_out >> 1;
				end
				JOB_LSB: begin
					n_data = n_out[0];
					n_out  = n_out >> 1;
				end
				default: begin
					n_data = n_out[7];
					n_out  = SW'({56'd0, n_out[6:0], 1'b0});
				end
			endcase
			n_phase = PH_LOW;
			n_wait  = half_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_shift_q <= '0;
			in_shift_q  <= '0;
			bits_left_q <= '0;
			wait_q      <= '0;
			phase_q     <= PH_IDLE;
			job_q       <= JOB_TICK;
			tck_q       <= 1'b0;
			tms_q       <= 1'b0;
			data_q      <= 1'b0;
		end else if (en) begin
			out_shift_q <= n_out;
			in_shift_q  <= n_in;
			bits_left_q <= n_bl;
			wait_q      <= n_wait;
			phase_q     <= n_phase;
			job_q       <= n_job;
			tck_q       <= n_tck;
			tms_q       <= n_tms;
			data_q      <= n_data;
		end
	end

	always_comb begin
		res.tck         = n_tck;
		res.tms_pin     = n_tms;
		res.data_pin    = n_data;
		res.pins_driven = port_en;
		res.busy_res    = (n_phase != PH_IDLE);
		res.done_res    = done;
		res.read_data   = 32'(n_in);
	end

	// TCK is high exactly in the high half
	a_tck_phase: assert property (@(posedge clk) disable iff (!arst_n)
		tck_q == (phase_q == PH_HIGH))
		else $error("tck level out of step with phase");

	// a running job always has bits and a live timer
	a_busy_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (bits_left_q != '0 && wait_q != '0))
		else $error("busy with empty counter or timer");

	// an idle tick leaves the shift state alone
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q == PH_IDLE && item.cmd == JOB_TICK) |=>
		($stable(out_shift_q) && $stable(in_shift_q) && phase_q == PH_IDLE))
		else $error("idle tick changed engine state");

	// a job never ends with TCK left high
	a_done_low: assert property (@(posedge clk) disable iff (!arst_n)
		(en && done) |-> !n_tck)
		else $error("job completed with tck high");

endmodule

`default_nettype wire

### rtl/jtag_shift_master.sv
// JTAG shift master top level: input register, tick engine, result register.
// A beat accepted into the input register is stepped by the tick engine and registered in the result
// register, which offers its result beat until it is taken.
// Throughput: one beat per cycle while result beats are taken; the tick engine updates all state once per beat.
// Reset (arst_n, asynchronous, active low): engine idle, pins low, half period 80, pins tristate.
// Depends on jsm_pkg, jsm_ifs, jsm_cfg and jsm_engine.
`default_nettype none

module jtag_shift_master import jsm_pkg::*; #(
	parameter int MAX_SHIFT_BITS = 32,
	parameter int DELAY_WIDTH    = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	jsm_req_if.sink                     req,
	jsm_rsp_if.source                   rsp,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [DELAY_WIDTH-1:0] cfg_wdata
);

	logic                   v_s1, v_s2, adv;
	req_item_t              item_s1;
	rsp_item_t              res, res_s2;
	logic [DELAY_WIDTH-1:0] half_period_q;
	logic                   port_en_q;

	assign adv       = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign rsp.valid = v_s2;
	assign rsp.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready)
				v_s1 <= req.valid;
			if (adv)
				v_s2 <= 1'b1;
			else if (rsp.ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= req.data;
		if (adv)
			res_s2 <= res;
	end

	jsm_cfg #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (cfg_wr_en),
		.index         (cfg_index),
		.wdata         (cfg_wdata),
		.half_period_q (half_period_q),
		.port_en_q     (port_en_q)
	);

	jsm_engine #(
		.MAX_SHIFT_BITS (MAX_SHIFT_BITS),
		.DELAY_WIDTH    (DELAY_WIDTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.item        (item_s1),
		.half_period (half_period_q),
		.port_en     (port_en_q),
		.res         (res)
	);

	// a stalled result beat is not overwritten
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rsp.ready) |=> (v_s2 && $stable(res_s2)))
		else $error("result beat lost under stall");

	// an input beat is not dropped while the first stage is full and stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(item_s1)))
		else $error("input beat lost under stall");

	// every engine step leaves a result beat behind
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2)
		else $error("engine step without result beat");

endmodule

`default_nettype wire
